// File: hdl/lpa_pkg.sv
`default_nettype none
package lpa_pkg;

  // Field and datapath widths
  localparam int unsigned SF_W      = 4;
  localparam int unsigned BW_W      = 20;
  localparam int unsigned CR_W      = 4;
  localparam int unsigned PRE_W     = 16;
  localparam int unsigned LEN_W     = 8;
  localparam int unsigned AIR_W     = 36;
  localparam int unsigned SYM_W     = 32;
  localparam int unsigned QUART_W   = 19;
  localparam int unsigned RECIP_W   = 20;
  localparam int unsigned RECIP_SH  = 20;
  localparam int unsigned OFF_W     = 8;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned DATA_W    = 20;
  localparam int unsigned DIV_STEPS = 32;

  // Register indexes on the configuration channel
  localparam logic [IDX_W-1:0] REG_SPREAD   = 3'd0;
  localparam logic [IDX_W-1:0] REG_BW       = 3'd1;
  localparam logic [IDX_W-1:0] REG_CODING   = 3'd2;
  localparam logic [IDX_W-1:0] REG_PREAMBLE = 3'd3;
  localparam logic [IDX_W-1:0] REG_IMPLICIT = 3'd4;
  localparam logic [IDX_W-1:0] REG_CRC      = 3'd5;

  // Reset values of the registers
  localparam logic [SF_W-1:0]  RST_SF       = 4'd7;
  localparam logic [BW_W-1:0]  RST_BW       = 20'd125000;
  localparam logic [CR_W-1:0]  RST_CR       = 4'd5;
  localparam logic [PRE_W-1:0] RST_PRE      = 16'd8;

  // Symbol count coefficients, symbol time scale and low rate threshold
  localparam logic [4:0]       C1_SF_LOW    = 5'd25;
  localparam logic [4:0]       C1_SF_HIGH   = 5'd17;
  localparam logic [OFF_W-1:0] C2_SF_HIGH   = 8'd8;
  localparam logic [OFF_W-1:0] CRC_BITS     = 8'd16;
  localparam logic [OFF_W-1:0] HDR_BITS     = 8'd20;
  localparam logic [QUART_W-1:0] PRE_EXTRA  = 19'd8;
  localparam logic [19:0]      USEC_PER_SEC = 20'd1000000;
  localparam logic [9:0]       LDRO_MS      = 10'd1000;

  typedef enum logic [1:0] {
    CAL_LOAD,
    CAL_DIV,
    CAL_DONE
  } cal_state_t;

  // Settings-derived values handed to the item pipeline
  typedef struct packed {
    logic [SYM_W-1:0]   sym_us;
    logic [RECIP_W-1:0] recip;
    logic [3:0]         k_m1;
    logic [OFF_W-1:0]   bit_off;
    logic [QUART_W-1:0] base_q;
    logic [CR_W-1:0]    coding;
    logic               ldro;
    logic               valid;
  } cal_t;

  // ceil(2^20 / k) for the quarter divisor k = 3..12
  function automatic logic [RECIP_W-1:0] recip_of(input logic [3:0] k);
    unique case (k)
      4'd3:    recip_of = 20'd349526;
      4'd4:    recip_of = 20'd262144;
      4'd5:    recip_of = 20'd209716;
      4'd6:    recip_of = 20'd174763;
      4'd7:    recip_of = 20'd149797;
      4'd8:    recip_of = 20'd131072;
      4'd9:    recip_of = 20'd116509;
      4'd10:   recip_of = 20'd104858;
      4'd11:   recip_of = 20'd95326;
      4'd12:   recip_of = 20'd87382;
      default: recip_of = 20'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: hdl/lpa_cfg.sv
`default_nettype none
module lpa_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [lpa_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [lpa_pkg::DATA_W-1:0]  cfg_data,
  output logic                             busy,
  output lpa_pkg::cal_t                    cal
);
  import lpa_pkg::*;

  logic [SF_W-1:0]  sf;
  logic [BW_W-1:0]  bw;
  logic [CR_W-1:0]  cr;
  logic [PRE_W-1:0] pre;
  logic             implicit_hdr;
  logic             crc;
  logic             wr;

  cal_state_t state, state_next;
  logic       div_load, div_step;

  logic [BW_W-1:0]  rem, rem_next;
  logic [SYM_W-1:0] quo;
  logic [4:0]       cnt;
  logic [BW_W:0]    trial;
  logic             ge;
  logic [SYM_W-1:0] dividend;

  logic               sf_ok, ldro, low_sf;
  logic [SF_W-1:0]    k;
  logic [31:0]        ldro_lhs, ldro_rhs;
  logic               ldro_r, base_ok_r;
  logic [3:0]         k_m1_r;
  logic [RECIP_W-1:0] recip_r;
  logic [OFF_W-1:0]   off_r, off_next;
  logic [QUART_W-1:0] base_r, base_next;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  // Hold the programmed settings
  always_ff @(posedge clk) begin
    if (rst) begin
      sf           <= RST_SF;
      bw           <= RST_BW;
      cr           <= RST_CR;
      pre          <= RST_PRE;
      implicit_hdr <= 1'b0;
      crc          <= 1'b1;
    end else if (wr) begin
      unique case (cfg_index)
        REG_SPREAD:   sf           <= cfg_data[SF_W-1:0];
        REG_BW:       bw           <= cfg_data[BW_W-1:0];
        REG_CODING:   cr           <= cfg_data[CR_W-1:0];
        REG_PREAMBLE: pre          <= cfg_data[PRE_W-1:0];
        REG_IMPLICIT: implicit_hdr <= cfg_data[0];
        REG_CRC:      crc          <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Sequence the symbol time division after reset and after every write
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CAL_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    if (wr) begin
      state_next = CAL_LOAD;
    end else begin
      unique case (state)
        CAL_LOAD: state_next = CAL_DIV;
        CAL_DIV:  state_next = (cnt == 5'(DIV_STEPS - 1)) ? CAL_DONE : CAL_DIV;
        CAL_DONE: state_next = CAL_DONE;
        default:  state_next = CAL_LOAD;
      endcase
    end
  end

  always_comb begin
    busy     = 1'b1;
    div_load = 1'b0;
    div_step = 1'b0;
    unique case (state)
      CAL_LOAD: div_load = 1'b1;
      CAL_DIV:  div_step = 1'b1;
      CAL_DONE: busy     = 1'b0;
      default:  busy     = 1'b1;
    endcase
  end

  // Restoring divide of 1e6 * 2^sf by the bandwidth, one quotient bit a cycle
  assign dividend = {12'd0, USEC_PER_SEC} << sf;
  assign trial    = {rem, quo[SYM_W-1]};
  assign ge       = (trial >= {1'b0, bw});
  assign rem_next = ge ? BW_W'(trial - {1'b0, bw}) : trial[BW_W-1:0];

  always_ff @(posedge clk) begin
    if (div_load) begin
      rem <= '0;
      quo <= dividend;
      cnt <= '0;
    end else if (div_step) begin
      rem <= rem_next;
      quo <= {quo[SYM_W-2:0], ge};
      cnt <= cnt + 5'd1;
    end
  end

  // Low data rate threshold and per-setting coefficients
  assign sf_ok    = (sf >= 4'd5) && (sf <= 4'd12);
  assign low_sf   = (sf == 4'd5) || (sf == 4'd6);
  assign ldro_lhs = {22'd0, LDRO_MS} << sf;
  assign ldro_rhs = {8'd0, bw, 4'd0};
  assign ldro     = sf_ok && (bw != '0) && (ldro_lhs >= ldro_rhs);
  assign k        = ldro ? (sf - 4'd2) : sf;

  assign off_next = (crc ? CRC_BITS : 8'd0) + (low_sf ? 8'd0 : C2_SF_HIGH)
                  + (implicit_hdr ? 8'd0 : HDR_BITS) - {2'b00, sf, 2'b00};
  assign base_next = {({1'b0, pre} + 17'(PRE_EXTRA)), 2'b00}
                   + QUART_W'(low_sf ? C1_SF_LOW : C1_SF_HIGH);

  always_ff @(posedge clk) begin
    ldro_r    <= ldro;
    base_ok_r <= sf_ok && (bw != '0) && (cr != '0);
    k_m1_r    <= k - 4'd1;
    recip_r   <= recip_of(k);
    off_r     <= off_next;
    base_r    <= base_next;
  end

  always_comb begin
    cal.sym_us  = quo;
    cal.recip   = recip_r;
    cal.k_m1    = k_m1_r;
    cal.bit_off = off_r;
    cal.base_q  = base_r;
    cal.coding  = cr;
    cal.ldro    = ldro_r;
    cal.valid   = base_ok_r && (quo != '0);
  end

endmodule
`default_nettype wire

// File: hdl/lpa_pipe.sv
`default_nettype none
module lpa_pipe (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic [lpa_pkg::LEN_W-1:0]  payload_length,
  input  wire lpa_pkg::cal_t              cal,
  output logic                            done,
  output logic [lpa_pkg::AIR_W-1:0]       airtime_us,
  output logic                            low_rate_opt,
  output logic                            settings_valid
);
  import lpa_pkg::*;

  localparam int unsigned PROD2_W = 10 + RECIP_W;
  localparam int unsigned PROD4_W = SYM_W + QUART_W;

  logic v1, v2, v3, v4;

  logic [12:0]        bits_s;
  logic [11:0]        bits;
  logic [9:0]         quarter_bits;
  logic [9:0]         n1;
  logic [PROD2_W-1:0] prod2;
  logic [9:0]         coded2;
  logic [13:0]        cq;
  logic [QUART_W-1:0] q3;
  logic [PROD4_W-1:0] prod4;
  logic [PROD4_W-3:0] air;

  // Advance the valid bits; the receiver never stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      done <= v4;
    end
  end

  // Stage 1: payload bit count, clamp at zero, quarter it and bias for ceiling
  assign bits_s = {2'b00, payload_length, 3'b000} + {{5{cal.bit_off[OFF_W-1]}}, cal.bit_off};
  assign bits   = bits_s[12] ? 12'd0 : bits_s[11:0];
  assign quarter_bits = 10'((13'(bits) + 13'd3) >> 2);

  always_ff @(posedge clk) begin
    n1 <= quarter_bits + {6'd0, cal.k_m1};
  end

  // Stage 2: divide by k through the reciprocal
  assign prod2 = PROD2_W'(n1) * PROD2_W'(cal.recip);

  always_ff @(posedge clk) begin
    coded2 <= prod2[PROD2_W-1:RECIP_SH];
  end

  // Stage 3: quarter-symbol count
  assign cq = 14'(coded2) * 14'(cal.coding);

  always_ff @(posedge clk) begin
    q3 <= cal.base_q + QUART_W'({cq, 2'b00});
  end

  // Stage 4: symbol time times quarter symbols
  always_ff @(posedge clk) begin
    prod4 <= PROD4_W'(cal.sym_us) * PROD4_W'(q3);
  end

  // Stage 5: drop the quarter scaling, saturate, gate on valid settings
  assign air = prod4[PROD4_W-1:2];

  always_ff @(posedge clk) begin
    low_rate_opt   <= cal.ldro;
    settings_valid <= cal.valid;
    if (!cal.valid) begin
      airtime_us <= '0;
    end else if (air[PROD4_W-3:AIR_W] != '0) begin
      airtime_us <= '1;
    end else begin
      airtime_us <= air[AIR_W-1:0];
    end
  end

endmodule
`default_nettype wire

// File: hdl/lora_packet_airtime.sv
`default_nettype none
// LoRa packet time on air. Pulse start with a payload length while busy is low;
// the result (airtime_us, low_rate_opt, settings_valid) comes out of the pipeline
// registers and sits on the output ports for exactly one cycle, marked by done,
// and the receiver has no way to hold it off. A new length can be started every
// cycle while busy is low, so one result leaves per cycle through the five-stage
// datapath (bit count, reciprocal divide, quarter-symbol sum, symbol-time
// multiply, saturate). The symbol time is divided out once per setting by a
// one-bit-per-cycle divider: after reset and after every configuration write busy
// stays high while it runs. Configuration writes are always taken.
module lora_packet_airtime (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [lpa_pkg::LEN_W-1:0]   payload_length,
  output logic                             done,
  output logic [lpa_pkg::AIR_W-1:0]        airtime_us,
  output logic                             low_rate_opt,
  output logic                             settings_valid,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [lpa_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [lpa_pkg::DATA_W-1:0]  cfg_data
);
  import lpa_pkg::*;

  cal_t cal;
  logic accept;

  assign accept = start & ~busy;

  // Settings registers and symbol time divider
  lpa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .cal       (cal)
  );

  // Per-packet datapath
  lpa_pipe u_pipe (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (accept),
    .payload_length (payload_length),
    .cal            (cal),
    .done           (done),
    .airtime_us     (airtime_us),
    .low_rate_opt   (low_rate_opt),
    .settings_valid (settings_valid)
  );

endmodule
`default_nettype wire

// File: tb/sv/lora_packet_airtime_tb.sv
`default_nettype none
module lora_packet_airtime_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpa_pkg::*;

  // Indexes past the register list; writes there must be dropped
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam longint AIR_CEIL = 64'hF_FFFF_FFFF;

  typedef struct packed {
    logic [AIR_W-1:0] air;
    logic             ldro;
    logic             ok;
  } airtime_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [LEN_W-1:0] payload_length = '0;
  logic done;
  logic [AIR_W-1:0] airtime_us;
  logic low_rate_opt;
  logic settings_valid;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the radio settings
  logic [SF_W-1:0] sf_q = RST_SF;
  logic [BW_W-1:0] bw_q = RST_BW;
  logic [CR_W-1:0] cr_q = RST_CR;
  logic [PRE_W-1:0] pre_q = RST_PRE;
  logic implicit_q = 1'b0;
  logic crc_q = 1'b1;

  logic [LEN_W-1:0] length_q[$];
  airtime_t pending_airtime[$];
  int issued_cnt = 0;
  int accepted_cnt = 0;
  int err_cnt = 0;
  int gap_left = 0;
  logic item_taken = 1'b0;
  bit idle_on = 1'b1;

  lora_packet_airtime dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .payload_length (payload_length),
    .done           (done),
    .airtime_us     (airtime_us),
    .low_rate_opt   (low_rate_opt),
    .settings_valid (settings_valid),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Time on air for one payload length under the shadow settings
  function automatic airtime_t predict_airtime(input logic [LEN_W-1:0] len);
    airtime_t r;
    bit sf_ok;
    longint sym, c1, c2, div, sbits, coded, quarters, total;
    sf_ok = (sf_q >= 4'd5) && (sf_q <= 4'd12);
    r.air = '0;
    r.ok = 1'b0;
    r.ldro = sf_ok && (bw_q != '0) && ((64'd1000 << sf_q) >= 64'd16 * bw_q);
    if (!sf_ok || bw_q == '0 || cr_q == '0) return r;
    sym = longint'((64'd1000000 << sf_q) / bw_q);
    if (sym == 0) return r;
    // SF5 and SF6 use their own coefficients
    if (sf_q == 4'd5 || sf_q == 4'd6) begin
      c1 = 25;
      c2 = 0;
    end else begin
      c1 = 17;
      c2 = 8;
    end
    div = r.ldro ? 4 * (longint'(sf_q) - 2) : 4 * longint'(sf_q);
    sbits = 8 * longint'(len) + (crc_q ? 16 : 0) - 4 * longint'(sf_q) + c2
          + (implicit_q ? 0 : 20);
    if (sbits < 0) sbits = 0;
    coded = (sbits + div - 1) / div;
    quarters = (longint'(pre_q) + 8) * 4 + c1 + coded * longint'(cr_q) * 4;
    total = (sym * quarters) / 4;
    if (total > AIR_CEIL) total = AIR_CEIL;
    r.air = total[AIR_W-1:0];
    r.ok = 1'b1;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive payload lengths from the queue, holding start until the transfer
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !item_taken) begin
      // hold the current item
    end else if (gap_left != 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (length_q.size() != 0) begin
      start <= 1'b1;
      payload_length <= length_q.pop_front();
      gap_left <= pick_gap();
    end else begin
      start <= 1'b0;
    end
  end

  // Check each result against the oldest prediction, then record new transfers
  always @(posedge clk) begin
    airtime_t exp_r;
    if (!rst && done) begin
      if (pending_airtime.size() == 0) begin
        $error("unexpected result: airtime_us %0d", airtime_us);
        err_cnt++;
      end else begin
        exp_r = pending_airtime.pop_front();
        if (airtime_us !== exp_r.air) begin
          $error("airtime_us: expected %0d, actual %0d", exp_r.air, airtime_us);
          err_cnt++;
        end
        if (low_rate_opt !== exp_r.ldro) begin
          $error("low_rate_opt: expected %0d, actual %0d", exp_r.ldro, low_rate_opt);
          err_cnt++;
        end
        if (settings_valid !== exp_r.ok) begin
          $error("settings_valid: expected %0d, actual %0d", exp_r.ok, settings_valid);
          err_cnt++;
        end
      end
    end
    item_taken <= !rst && start && !busy;
    if (!rst && start && !busy) begin
      pending_airtime.push_back(predict_airtime(payload_length));
      accepted_cnt <= accepted_cnt + 1;
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    // mirror the transfer, masked to each register's width
    case (idx)
      REG_SPREAD:   sf_q = data[SF_W-1:0];
      REG_BW:       bw_q = data[BW_W-1:0];
      REG_CODING:   cr_q = data[CR_W-1:0];
      REG_PREAMBLE: pre_q = data[PRE_W-1:0];
      REG_IMPLICIT: implicit_q = data[0];
      REG_CRC:      crc_q = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(input logic [SF_W-1:0] sf, input logic [BW_W-1:0] bw,
                         input logic [CR_W-1:0] cr, input logic [PRE_W-1:0] pre,
                         input logic impl, input logic crc);
    write_reg(REG_SPREAD, {16'hA5C3, sf});
    write_reg(REG_BW, bw);
    write_reg(REG_CODING, {16'h5A3C, cr});
    write_reg(REG_PREAMBLE, {4'hF, pre});
    write_reg(REG_IMPLICIT, {19'h7FFFE, impl});
    write_reg(REG_CRC, {19'h2AAAA, crc});
  endtask

  task automatic send(input logic [LEN_W-1:0] len);
    length_q.push_back(len);
    issued_cnt++;
  endtask

  // Wait until every item is taken and every result is back, then let the pipe drain
  task automatic settle();
    @(negedge clk);
    while (accepted_cnt != issued_cnt || pending_airtime.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    logic [BW_W-1:0] common_bw[10];
    logic [SF_W-1:0] sf;
    logic [BW_W-1:0] bw;
    logic [CR_W-1:0] cr;
    logic [PRE_W-1:0] pre;
    int r;
    common_bw = '{20'd7800, 20'd10400, 20'd15600, 20'd20800, 20'd31250,
                  20'd41700, 20'd62500, 20'd125000, 20'd250000, 20'd500000};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings, payload extremes
    send(8'd0);
    send(8'd255);
    send(8'd85);
    send(8'd170);
    settle();

    // SF5 coefficients, implicit header without CRC, bit count clamped at zero
    set_all(4'd5, 20'd500000, 4'd8, 16'd0, 1'b1, 1'b0);
    send(8'd0);
    send(8'd255);
    settle();

    // SF6 at the widest bandwidth, largest coding denominator
    set_all(4'd6, 20'hFFFFF, 4'd15, 16'd3, 1'b0, 1'b1);
    send(8'd1);
    settle();

    // SF12 with low rate optimisation and the longest preamble
    set_all(4'd12, 20'd125000, 4'd5, 16'hFFFF, 1'b0, 1'b1);
    send(8'd255);
    send(8'd0);
    settle();

    // Tiny bandwidth saturates the airtime
    write_reg(REG_BW, 20'd1);
    send(8'd255);
    settle();

    // Zero coding denominator: invalid, low rate flag still set
    write_reg(REG_BW, 20'd7800);
    write_reg(REG_CODING, 20'd0);
    send(8'd10);
    settle();

    // Zero bandwidth
    write_reg(REG_CODING, 20'd5);
    write_reg(REG_BW, 20'd0);
    send(8'd20);
    settle();

    // Spreading factors outside the usable range
    write_reg(REG_BW, 20'd125000);
    write_reg(REG_SPREAD, 20'd4);
    send(8'd30);
    settle();
    write_reg(REG_SPREAD, 20'd13);
    send(8'd31);
    settle();
    write_reg(REG_SPREAD, 20'hFFFFF);
    send(8'd32);
    settle();
    write_reg(REG_SPREAD, 20'd0);
    send(8'd33);
    settle();

    // Writes past the register list are dropped
    write_reg(REG_SPREAD, 20'd7);
    write_reg(REG_SPARE_LO, 20'hFFFFF);
    write_reg(REG_SPARE_HI, 20'hFFFFF);
    send(8'd50);
    settle();

    // Low rate threshold exactly met, then just missed
    set_all(4'd10, 20'd64000, 4'd6, 16'd8, 1'b0, 1'b1);
    send(8'd100);
    settle();
    write_reg(REG_BW, 20'd64001);
    send(8'd100);
    settle();

    // Random settings, mostly usable, each with a run of random lengths
    for (int p = 0; p < 16; p++) begin
      idle_on = (p % 4 != 3);
      r = $urandom_range(0, 99);
      sf = (r < 80) ? 4'($urandom_range(5, 12)) : 4'($urandom_range(0, 15));
      r = $urandom_range(0, 99);
      if (r < 60) bw = common_bw[$urandom_range(0, 9)];
      else if (r < 85) bw = 20'($urandom_range(1, 20'hFFFFF));
      else bw = 20'($urandom_range(0, 100));
      r = $urandom_range(0, 99);
      cr = (r < 80) ? 4'($urandom_range(5, 8)) : 4'($urandom_range(0, 15));
      r = $urandom_range(0, 99);
      pre = (r < 70) ? 16'($urandom_range(6, 20)) : 16'($urandom_range(0, 16'hFFFF));
      write_reg(REG_SPREAD, {16'($urandom_range(0, 16'hFFFF)), sf});
      write_reg(REG_BW, bw);
      write_reg(REG_CODING, {16'($urandom_range(0, 16'hFFFF)), cr});
      write_reg(REG_PREAMBLE, {4'($urandom_range(0, 15)), pre});
      write_reg(REG_IMPLICIT, 20'($urandom_range(0, 20'hFFFFF)));
      write_reg(REG_CRC, 20'($urandom_range(0, 20'hFFFFF)));
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                  20'($urandom_range(0, 20'hFFFFF)));
      for (int i = 0; i < 53; i++) begin
        r = $urandom_range(0, 19);
        if (r == 0) send(8'd0);
        else if (r == 1) send(8'd255);
        else send(8'($urandom_range(0, 255)));
      end
      settle();
    end

    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Give up if the run stalls
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
hdl/lpa_pkg.sv
hdl/lpa_cfg.sv
hdl/lpa_pipe.sv
hdl/lora_packet_airtime.sv
tb/sv/lora_packet_airtime_tb.sv
